[rtl/assert_macros.svh]
// assertion macros for the rtl files that check themselves
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/lpm_pkg.sv]
// shared widths, stage counts and types for the line pair midpoint block
// no dependencies; used by lpm_div and line_pair_midpoint
package lpm_pkg;

    // coordinate format, signed q8.8
    localparam int COORD_W  = 16;
    localparam int NUM_IN   = 12;
    localparam int NUM_OUT  = 3;
    localparam int PSUM_W   = COORD_W + 1;

    // quotient format, q16.16
    localparam int QFRAC    = 16;
    localparam int QW       = 32;

    // intermediate widths
    localparam int W_W      = COORD_W + 1;
    localparam int PC_W     = 2 * COORD_W;
    localparam int PA_W     = COORD_W + W_W;
    localparam int C_W      = PC_W + 1;
    localparam int A_W      = PA_W + 1;
    localparam int CC_W     = 2 * C_W;
    localparam int AC_W     = A_W + C_W;
    localparam int DEN_W    = 64;
    localparam int MAG_W    = AC_W - 1;
    localparam int LIM_W    = 32;

    // back end widths
    localparam int PROD_W   = QW + COORD_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int SH_W     = ACC_W - (QFRAC + 1);

    // pipeline depth
    localparam int FRONT_STG = 5;
    localparam int BACK_STG  = 3;
    localparam int NSTG      = FRONT_STG + QW + BACK_STG;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;

    // operands handed to one divider
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QW-1:0]    low;
        logic [DEN_W-1:0] den;
        logic             ovf;
    } div_in_t;

    // magnitude quotient and overflow flag
    typedef struct packed {
        logic [QW-1:0] q;
        logic          ovf;
    } div_out_t;

    // data that rides alongside the dividers
    typedef struct packed {
        logic              par;
        logic              s_neg;
        logic              t_neg;
        coord_t [2:0]      d1;
        coord_t [2:0]      d2;
        psum_t  [2:0]      psum;
    } side_t;

endpackage

[rtl/lpm_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on lpm_pkg for widths and the operand structs
module lpm_div
    import lpm_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  div_in_t  din,
    output div_out_t dout
);

    logic [DEN_W-1:0] rem_reg  [0:QW];
    logic [QW-1:0]    low_reg  [0:QW];
    logic [DEN_W-1:0] den_reg  [0:QW];
    logic [QW-1:0]    q_reg    [0:QW];
    logic             ovf_reg  [0:QW];

    logic [DEN_W-1:0] rem_next [1:QW];
    logic [QW-1:0]    q_next   [1:QW];

    // one compare and subtract per stage
    always_comb
    begin
        logic [DEN_W:0]   tr;
        logic [DEN_W+1:0] diff;
        for (int k = 1; k <= QW; k++)
        begin
            tr   = {rem_reg[k-1], low_reg[k-1][QW-1]};
            diff = {1'b0, tr} - {2'b00, den_reg[k-1]};
            if (!diff[DEN_W+1])
            begin
                rem_next[k] = diff[DEN_W-1:0];
                q_next[k]   = {q_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = tr[DEN_W-1:0];
                q_next[k]   = {q_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // stage registers advance together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= din.rem;
            low_reg[0] <= din.low;
            den_reg[0] <= din.den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= din.ovf;
            for (int k = 1; k <= QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next[k];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign dout.q   = q_reg[QW];
    assign dout.ovf = ovf_reg[QW];

endmodule

[rtl/line_pair_midpoint.sv]
// line pair midpoint: closest-point midpoint of two 3d lines
// depends on lpm_pkg, lpm_div and assert_macros.svh
//
// usage
// - input stream s_axis carries one line pair per request: twelve signed
//   q8.8 coordinates, p1, dir1, p2, dir2, x then y then z
// - output stream m_axis returns the midpoint in q8.8 and a parallel flag
// - cfg write channel sets the parallel threshold on |d1 x d2|^2 (q.32)
// - a request passes through the cross and dot products, the dividers (one
//   quotient bit per stage) and then saturation, scaling and rounding
// - one request per cycle when m_axis does not stall; the two 32-stage
//   dividers for s and t run side by side, each stage taking a new item
// - reset clears every valid bit and sets the threshold to 1
// - when the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline holds and s_axis_tready drops until the result leaves
`include "assert_macros.svh"

module line_pair_midpoint
    import lpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // p1_x, p1_y, p1_z, dir1_x, dir1_y, dir1_z,
    // p2_x, p2_y, p2_z, dir2_x, dir2_y, dir2_z
    input  logic [NUM_IN*COORD_W-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // mid_x, mid_y, mid_z
    output logic [NUM_OUT*COORD_W-1:0] m_axis_tdata,
    // parallel
    output logic [0:0]               m_axis_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIM_W-1:0]         cfg_data
);

    logic              en;
    logic [NSTG-1:0]   vld_reg;
    logic [LIM_W-1:0]  limit_reg;
    coord_t [NUM_IN-1:0] in_f;

    // stage 1 products
    logic signed [PC_W-1:0] s1_cpa_reg [0:2];
    logic signed [PC_W-1:0] s1_cpb_reg [0:2];
    logic signed [PA_W-1:0] s1_apa_reg [0:2];
    logic signed [PA_W-1:0] s1_apb_reg [0:2];
    logic signed [PA_W-1:0] s1_bpa_reg [0:2];
    logic signed [PA_W-1:0] s1_bpb_reg [0:2];
    coord_t [2:0]           s1_d1_reg, s1_d2_reg;
    psum_t  [2:0]           s1_psum_reg;

    // stage 2 cross products
    logic signed [C_W-1:0]  s2_c_reg [0:2];
    logic signed [A_W-1:0]  s2_a_reg [0:2];
    logic signed [A_W-1:0]  s2_b_reg [0:2];
    coord_t [2:0]           s2_d1_reg, s2_d2_reg;
    psum_t  [2:0]           s2_psum_reg;

    // stage 3 dot product terms
    logic signed [CC_W-1:0] s3_cc_reg [0:2];
    logic signed [AC_W-1:0] s3_ac_reg [0:2];
    logic signed [AC_W-1:0] s3_bc_reg [0:2];
    coord_t [2:0]           s3_d1_reg, s3_d2_reg;
    psum_t  [2:0]           s3_psum_reg;

    // stage 4 sums
    logic [DEN_W-1:0]       s4_den_reg;
    logic signed [AC_W-1:0] s4_na_reg, s4_nb_reg;
    coord_t [2:0]           s4_d1_reg, s4_d2_reg;
    psum_t  [2:0]           s4_psum_reg;

    // divider feed and sideband
    div_in_t          sdiv_in, tdiv_in;
    div_out_t         sdiv_out, tdiv_out;
    side_t            side_next;
    side_t            sb_reg [0:QW];
    logic [MAG_W-1:0] na_mag, nb_mag;

    // back end
    logic signed [QW-1:0]     s_next, t_next;
    logic signed [QW-1:0]     bs_s_reg, bs_t_reg;
    side_t                    bs_side_reg;
    logic signed [PROD_W-1:0] bm_ps_reg [0:2];
    logic signed [PROD_W-1:0] bm_pt_reg [0:2];
    psum_t [2:0]              bm_psum_reg;
    logic                     bm_par_reg;
    coord_t [NUM_OUT-1:0]     out_next, out_reg;
    logic                     out_par_reg;

    // global advance: move unless a result waits on a stalled receiver
    assign en            = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = out_par_reg;
    assign cfg_ready     = 1'b1;
    assign in_f          = s_axis_tdata;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // stages 1 to 3, one lane per axis
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [W_W-1:0] w_j, w_k;

        assign w_j = W_W'(in_f[J]) - W_W'(in_f[6+J]);
        assign w_k = W_W'(in_f[K]) - W_W'(in_f[6+K]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // c = d1 x d2, a = d2 x w, b = d1 x w
                s1_cpa_reg[g]  <= in_f[3+J] * in_f[9+K];
                s1_cpb_reg[g]  <= in_f[3+K] * in_f[9+J];
                s1_apa_reg[g]  <= in_f[9+J] * w_k;
                s1_apb_reg[g]  <= in_f[9+K] * w_j;
                s1_bpa_reg[g]  <= in_f[3+J] * w_k;
                s1_bpb_reg[g]  <= in_f[3+K] * w_j;

                s2_c_reg[g]    <= C_W'(s1_cpa_reg[g]) - C_W'(s1_cpb_reg[g]);
                s2_a_reg[g]    <= A_W'(s1_apa_reg[g]) - A_W'(s1_apb_reg[g]);
                s2_b_reg[g]    <= A_W'(s1_bpa_reg[g]) - A_W'(s1_bpb_reg[g]);

                s3_cc_reg[g]   <= s2_c_reg[g] * s2_c_reg[g];
                s3_ac_reg[g]   <= s2_a_reg[g] * s2_c_reg[g];
                s3_bc_reg[g]   <= s2_b_reg[g] * s2_c_reg[g];
            end
        end
    end

    // directions and point sums ride along stages 1 to 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_psum_reg[i] <= PSUM_W'(in_f[i]) + PSUM_W'(in_f[6+i]);
            end
            s1_d1_reg   <= in_f[5:3];
            s1_d2_reg   <= in_f[11:9];

            s2_d1_reg   <= s1_d1_reg;
            s2_d2_reg   <= s1_d2_reg;
            s2_psum_reg <= s1_psum_reg;

            s3_d1_reg   <= s2_d1_reg;
            s3_d2_reg   <= s2_d2_reg;
            s3_psum_reg <= s2_psum_reg;
        end
    end

    // stage 4: |c|^2 and the two numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_den_reg  <= s3_cc_reg[0][DEN_W-1:0] + s3_cc_reg[1][DEN_W-1:0]
                         + s3_cc_reg[2][DEN_W-1:0];
            s4_na_reg   <= s3_ac_reg[0] + s3_ac_reg[1] + s3_ac_reg[2];
            s4_nb_reg   <= s3_bc_reg[0] + s3_bc_reg[1] + s3_bc_reg[2];
            s4_d1_reg   <= s3_d1_reg;
            s4_d2_reg   <= s3_d2_reg;
            s4_psum_reg <= s3_psum_reg;
        end
    end

    // stage 5: magnitudes, overflow check and parallel test
    always_comb
    begin
        logic signed [AC_W-1:0] neg_a, neg_b;
        neg_a  = -s4_na_reg;
        neg_b  = -s4_nb_reg;
        na_mag = s4_na_reg[AC_W-1] ? neg_a[MAG_W-1:0] : s4_na_reg[MAG_W-1:0];
        nb_mag = s4_nb_reg[AC_W-1] ? neg_b[MAG_W-1:0] : s4_nb_reg[MAG_W-1:0];

        sdiv_in.rem = DEN_W'(na_mag[MAG_W-1:QFRAC]);
        sdiv_in.low = {na_mag[QFRAC-1:0], {(QW-QFRAC){1'b0}}};
        sdiv_in.den = s4_den_reg;
        sdiv_in.ovf = DEN_W'(na_mag[MAG_W-1:QFRAC]) >= s4_den_reg;

        tdiv_in.rem = DEN_W'(nb_mag[MAG_W-1:QFRAC]);
        tdiv_in.low = {nb_mag[QFRAC-1:0], {(QW-QFRAC){1'b0}}};
        tdiv_in.den = s4_den_reg;
        tdiv_in.ovf = DEN_W'(nb_mag[MAG_W-1:QFRAC]) >= s4_den_reg;

        side_next.par   = (s4_den_reg == '0) || (s4_den_reg < DEN_W'(limit_reg));
        side_next.s_neg = s4_na_reg[AC_W-1];
        side_next.t_neg = s4_nb_reg[AC_W-1];
        side_next.d1    = s4_d1_reg;
        side_next.d2    = s4_d2_reg;
        side_next.psum  = s4_psum_reg;
    end

    lpm_div u_div_s
    (
        .clk  (clk),
        .en   (en),
        .din  (sdiv_in),
        .dout (sdiv_out)
    );

    lpm_div u_div_t
    (
        .clk  (clk),
        .en   (en),
        .din  (tdiv_in),
        .dout (tdiv_out)
    );

    // sideband delay matching the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= side_next;
            for (int k = 1; k <= QW; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // signed quotients, saturated to 32 bits
    always_comb
    begin
        if (sdiv_out.ovf || sdiv_out.q[QW-1])
        begin
            s_next = sb_reg[QW].s_neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        else
        begin
            s_next = sb_reg[QW].s_neg ? -$signed(sdiv_out.q) : $signed(sdiv_out.q);
        end
        if (tdiv_out.ovf || tdiv_out.q[QW-1])
        begin
            t_next = sb_reg[QW].t_neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        else
        begin
            t_next = sb_reg[QW].t_neg ? -$signed(tdiv_out.q) : $signed(tdiv_out.q);
        end
    end

    // saturation stage and scaling products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bs_s_reg    <= s_next;
            bs_t_reg    <= t_next;
            bs_side_reg <= sb_reg[QW];
            for (int i = 0; i < 3; i++)
            begin
                bm_ps_reg[i] <= bs_s_reg * bs_side_reg.d1[i];
                bm_pt_reg[i] <= bs_t_reg * bs_side_reg.d2[i];
            end
            bm_psum_reg <= bs_side_reg.psum;
            bm_par_reg  <= bs_side_reg.par;
        end
    end

    // halve with round half up, saturate, zero for parallel lines
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [SH_W-1:0]  sh;
        for (int i = 0; i < NUM_OUT; i++)
        begin
            acc = (ACC_W'(bm_psum_reg[i]) <<< QFRAC) + ACC_W'(bm_ps_reg[i])
                + ACC_W'(bm_pt_reg[i]) + (ACC_W'(1) <<< QFRAC);
            sh  = acc[ACC_W-1:QFRAC+1];
            if (bm_par_reg)
            begin
                out_next[i] = '0;
            end
            else if (sh > SH_W'(coord_t'({1'b0, {(COORD_W-1){1'b1}}})))
            begin
                out_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
            else if (sh < SH_W'(coord_t'({1'b1, {(COORD_W-1){1'b0}}})))
            begin
                out_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                out_next[i] = sh[COORD_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg     <= out_next;
            out_par_reg <= bm_par_reg;
        end
    end

    // checks
    `ASSERT_CLK(a_par_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "par point")
    `ASSERT_NEXT(a_req_enters, s_axis_tvalid && s_axis_tready, vld_reg[0], "request lost")
    `ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, limit_reg == $past(cfg_data), "cfg lost")

endmodule
